### src/multilevel_feedback_queue_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel feedback queue scheduler.
// Each macro expects a clock named aclk and an active low reset aresetn.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define MFQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mfqs assertion failed");

// Next-cycle implication.
`define MFQS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mfqs assertion failed");

`endif

### src/mfqs_pkg.sv
// ----------------------------------------------------------------------------
// mfqs_pkg
// Types, constants and helpers shared by the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

    localparam int LEVELS    = 4;
    localparam int JOB_SLOTS = 64;
    localparam int SLOT_W    = $clog2(JOB_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  cls;
        logic [15:0] len;
        logic [15:0] id;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_BOOST,
        ST_DONE
    } state_t;

    localparam logic [2:0] CFG_SLICE0 = 3'd0;
    localparam logic [2:0] CFG_SLICE1 = 3'd1;
    localparam logic [2:0] CFG_SLICE2 = 3'd2;
    localparam logic [2:0] CFG_SLICE3 = 3'd3;
    localparam logic [2:0] CFG_BOOST  = 3'd4;

    localparam logic OP_ARRIVAL  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [15:0] RESET_SLICE0 = 16'd10;
    localparam logic [15:0] RESET_SLICE1 = 16'd20;
    localparam logic [15:0] RESET_SLICE2 = 16'd25;
    localparam logic [15:0] RESET_SLICE3 = 16'd30;
    localparam logic [7:0]  RESET_BOOST  = 8'd10;

    function automatic logic [15:0] reset_slice(input int lvl);
        logic [15:0] r;
        if (lvl >= LEVELS - 1) begin
            r = RESET_SLICE3;
        end else if (lvl == 0) begin
            r = RESET_SLICE0;
        end else if (lvl == 1) begin
            r = RESET_SLICE1;
        end else begin
            r = RESET_SLICE2;
        end
        return r;
    endfunction

endpackage

### src/mfqs_ram.sv
// ----------------------------------------------------------------------------
// mfqs_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Four-level feedback queue scheduler over linked lists in block memory.
// ----------------------------------------------------------------------------
// Each request passes through four steps from acceptance to a loaded result:
// accept, read the job store, link and free list memories, update and write
// back, and load the output register. A boost adds one step for each level
// below level 0, since the level 0 tail link is written through the single
// link memory port. No clearing pass is needed after reset.
module multilevel_feedback_queue_scheduler
    import mfqs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // job_id, job_length, job_class
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // done_id, done_class, done_length, finish_time
    output logic [2:0]  m_tuser,   // finished, all_empty, rejected
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic        op_reg;
    logic [15:0] in_id_reg, in_len_reg;
    logic [7:0]  in_cls_reg;
    logic [15:0] slice_reg [4];
    logic [7:0]  boost_reg;

    slot_t       head_reg [LEVELS], head_next [LEVELS];
    slot_t       tail_reg [LEVELS], tail_next [LEVELS];
    logic [LEVELS-1:0] valid_reg, valid_next;
    logic [31:0] tol_reg [LEVELS], tol_next [LEVELS];
    logic [31:0] time_reg, time_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        empty_reg, empty_next;
    logic [CNT_W-1:0] fcount_reg, fcount_next, lw_reg, lw_next;
    lvl_t        lvl_reg, lvl_next, bl_reg, bl_next;
    logic        found_reg, found_next;
    logic        fresh_reg, fresh_next;

    logic        res_fin_reg, res_fin_next, res_rej_reg, res_rej_next;
    logic [15:0] res_id_reg, res_id_next, res_len_reg, res_len_next;
    logic [7:0]  res_cls_reg, res_cls_next;
    logic [31:0] res_time_reg, res_time_next;

    logic        st_we, ln_we, fl_we;
    slot_t       st_waddr, ln_waddr, fl_waddr, ln_wdata, fl_wdata;
    job_t        st_wdata, st_rdata;
    slot_t       rd_addr, fl_raddr, ln_rdata, fl_rdata;

    logic        out_load;

    mfqs_ram #(.WIDTH(JOB_W), .DEPTH(JOB_SLOTS)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(rd_addr), .rdata(st_rdata)
    );

    mfqs_ram #(.WIDTH(SLOT_W), .DEPTH(JOB_SLOTS)) u_link (
        .aclk(aclk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(rd_addr), .rdata(ln_rdata)
    );

    mfqs_ram #(.WIDTH(SLOT_W), .DEPTH(JOB_SLOTS)) u_free (
        .aclk(aclk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );

    function automatic logic [15:0] slice_sel(input lvl_t l, input logic [15:0] s0,
                                              input logic [15:0] s1, input logic [15:0] s2,
                                              input logic [15:0] s3);
        logic [15:0] r;
        if (int'(l) >= LEVELS - 1) begin
            r = s3;
        end else if (int'(l) == 0) begin
            r = s0;
        end else if (int'(l) == 1) begin
            r = s1;
        end else begin
            r = s2;
        end
        return r;
    endfunction

    // Level search and memory read addresses for the fetch cycle.
    lvl_t search_lvl;
    logic search_found;

    always_comb begin
        search_lvl   = '0;
        search_found = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (valid_reg[i]) begin
                search_lvl   = lvl_t'(i);
                search_found = 1'b1;
            end
        end
    end

    assign rd_addr  = head_reg[search_lvl];
    assign fl_raddr = slot_t'(fcount_reg - CNT_W'(1));
    assign s_tready = (state_reg == ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_EXEC;
            ST_EXEC: begin
                state_next = (cnt_reg > boost_reg) ? ST_BOOST : ST_DONE;
            end
            ST_BOOST: begin
                if (int'(bl_reg) == LEVELS - 1) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory writes.
    always_comb begin
        logic [SLOT_W-1:0] s;
        logic [CNT_W-1:0]  p;
        job_t              job;
        logic [15:0]       sl;
        logic              last;
        lvl_t              tgt;
        logic              do_append;
        logic [31:0]       add;
        logic [32:0]       sum;
        logic [LEVELS-1:0] pv;

        for (int i = 0; i < LEVELS; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            tol_next[i]  = tol_reg[i];
        end
        valid_next    = valid_reg;
        time_next     = time_reg;
        cnt_next      = cnt_reg;
        empty_next    = empty_reg;
        fcount_next   = fcount_reg;
        lw_next       = lw_reg;
        lvl_next      = lvl_reg;
        bl_next       = bl_reg;
        found_next    = found_reg;
        fresh_next    = fresh_reg;
        res_fin_next  = res_fin_reg;
        res_rej_next  = res_rej_reg;
        res_id_next   = res_id_reg;
        res_len_next  = res_len_reg;
        res_cls_next  = res_cls_reg;
        res_time_next = res_time_reg;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0;
        ln_we = 1'b0; ln_waddr = '0; ln_wdata = '0;
        fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0;
        s = '0;
        p = fcount_reg - CNT_W'(1);
        job = st_rdata;
        sl = slice_sel(lvl_reg, slice_reg[0], slice_reg[1], slice_reg[2], slice_reg[3]);
        last = (int'(lvl_reg) == LEVELS - 1);
        tgt = last ? lvl_reg : lvl_t'(lvl_reg + lvl_t'(1));
        do_append = 1'b0;
        add = '0;
        sum = '0;
        pv = valid_reg;

        unique case (state_reg)
            ST_FETCH: begin
                lvl_next   = search_lvl;
                found_next = search_found;
                fresh_next = (fcount_reg <= lw_reg);
            end
            ST_EXEC: begin
                res_fin_next = 1'b0; res_rej_next = 1'b0; res_id_next = '0;
                res_len_next = '0; res_cls_next = '0; res_time_next = '0;
                if (op_reg == OP_ARRIVAL) begin
                    if (fcount_reg == '0) begin
                        res_rej_next = 1'b1;
                    end else begin
                        s = fresh_reg ? slot_t'(CNT_W'(JOB_SLOTS - 1) - p) : fl_rdata;
                        st_we = 1'b1; st_waddr = s;
                        st_wdata = '{rem: in_len_reg, cls: in_cls_reg, len: in_len_reg,
                                     id: in_id_reg};
                        ln_we = 1'b1; ln_waddr = s; ln_wdata = head_reg[0];
                        if (!valid_reg[0]) tail_next[0] = s;
                        head_next[0]  = s;
                        valid_next[0] = 1'b1;
                        fcount_next   = p;
                        if (p < lw_reg) lw_next = p;
                    end
                end else if (!found_reg) begin
                    empty_next = 1'b1;
                end else begin
                    s = head_reg[lvl_reg];
                    if (s == tail_reg[lvl_reg]) begin
                        pv[lvl_reg] = 1'b0;
                    end else begin
                        head_next[lvl_reg] = ln_rdata;
                    end
                    if (!last && tol_reg[lvl_reg] == '0) begin
                        tol_next[lvl_reg] = {16'd0, sl};
                        add = {16'd0, sl};
                        do_append = 1'b1;
                    end else begin
                        if (!last) tol_next[lvl_reg] = tol_reg[lvl_reg] - {16'd0, job.rem};
                        if (job.rem > sl) begin
                            st_we = 1'b1; st_waddr = s;
                            st_wdata = job;
                            st_wdata.rem = job.rem - sl;
                            add = {16'd0, sl};
                            do_append = 1'b1;
                        end else begin
                            add = {16'd0, job.rem};
                            res_fin_next = 1'b1;
                            res_id_next  = job.id;
                            res_cls_next = job.cls;
                            res_len_next = job.len;
                            if (fcount_reg < CNT_W'(JOB_SLOTS)) begin
                                fl_we = 1'b1;
                                fl_waddr = slot_t'(fcount_reg);
                                fl_wdata = s;
                                fcount_next = fcount_reg + CNT_W'(1);
                            end
                        end
                    end
                    sum = {1'b0, time_reg} + {1'b0, add};
                    time_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (res_fin_next) res_time_next = time_next;
                    valid_next = pv;
                    if (do_append) begin
                        if (pv[tgt]) begin
                            ln_we = 1'b1; ln_waddr = tail_reg[tgt]; ln_wdata = s;
                        end else begin
                            head_next[tgt] = s;
                        end
                        valid_next[tgt] = 1'b1;
                        tail_next[tgt]  = s;
                    end
                end
                if (cnt_reg > boost_reg) begin
                    cnt_next = 8'd1;
                    bl_next  = lvl_t'(1);
                end else begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            ST_BOOST: begin
                if (valid_reg[bl_reg]) begin
                    if (valid_reg[0]) begin
                        ln_we = 1'b1; ln_waddr = tail_reg[0]; ln_wdata = head_reg[bl_reg];
                    end else begin
                        head_next[0] = head_reg[bl_reg];
                    end
                    valid_next[0]      = 1'b1;
                    tail_next[0]       = tail_reg[bl_reg];
                    valid_next[bl_reg] = 1'b0;
                end
                if (int'(bl_reg) != LEVELS - 1) bl_next = bl_reg + lvl_t'(1);
            end
            default: begin
            end
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            time_reg   <= '0;
            cnt_reg    <= '0;
            empty_reg  <= 1'b0;
            fcount_reg <= CNT_W'(JOB_SLOTS);
            lw_reg     <= CNT_W'(JOB_SLOTS);
            m_tvalid   <= 1'b0;
            slice_reg[0] <= RESET_SLICE0;
            slice_reg[1] <= RESET_SLICE1;
            slice_reg[2] <= RESET_SLICE2;
            slice_reg[3] <= RESET_SLICE3;
            boost_reg    <= RESET_BOOST;
            for (int i = 0; i < LEVELS; i++) begin
                tol_reg[i] <= {16'd0, reset_slice(i)};
            end
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            time_reg   <= time_next;
            cnt_reg    <= cnt_next;
            empty_reg  <= empty_next;
            fcount_reg <= fcount_next;
            lw_reg     <= lw_next;
            for (int i = 0; i < LEVELS; i++) begin
                tol_reg[i] <= tol_next[i];
            end
            if (out_load) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_SLICE0: slice_reg[0] <= cfg_wdata;
                    CFG_SLICE1: slice_reg[1] <= cfg_wdata;
                    CFG_SLICE2: slice_reg[2] <= cfg_wdata;
                    CFG_SLICE3: slice_reg[3] <= cfg_wdata;
                    CFG_BOOST:  boost_reg    <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            in_id_reg  <= s_tdata[15:0];
            in_len_reg <= s_tdata[31:16];
            in_cls_reg <= s_tdata[39:32];
        end
        for (int i = 0; i < LEVELS; i++) begin
            head_reg[i] <= head_next[i];
            tail_reg[i] <= tail_next[i];
        end
        lvl_reg      <= lvl_next;
        bl_reg       <= bl_next;
        found_reg    <= found_next;
        fresh_reg    <= fresh_next;
        res_fin_reg  <= res_fin_next;
        res_rej_reg  <= res_rej_next;
        res_id_reg   <= res_id_next;
        res_len_reg  <= res_len_next;
        res_cls_reg  <= res_cls_next;
        res_time_reg <= res_time_next;
        if (out_load) begin
            m_tdata <= {res_time_reg, res_len_reg, res_cls_reg, res_id_reg};
            m_tuser <= {res_rej_reg, empty_reg, res_fin_reg};
        end
    end

`include "multilevel_feedback_queue_scheduler_assert.svh"

    `MFQS_ASSERT_IMP(a_fcount_range, 1'b1, fcount_reg <= CNT_W'(JOB_SLOTS))
    `MFQS_ASSERT_IMP(a_lw_below_count, 1'b1, lw_reg <= fcount_reg)
    `MFQS_ASSERT_NXT(a_accept_fetch, s_tvalid && s_tready, state_reg == ST_FETCH)
    `MFQS_ASSERT_NXT(a_empty_sticky, empty_reg, empty_reg)

endmodule
